@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the instruction class decoder, used by the top level.
// Each macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cicd_pkg.sv @@
// Package for the instruction class decoder: class codes, match masks and
// the result type. It depends on nothing else.
package cicd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ClassW = 6;

  // Class codes.
  localparam logic [ClassW-1:0] CLS_INVALID = 6'd0;
  localparam logic [ClassW-1:0] CLS_B       = 6'd1;
  localparam logic [ClassW-1:0] CLS_BL      = 6'd2;
  localparam logic [ClassW-1:0] CLS_BX      = 6'd3;
  localparam logic [ClassW-1:0] CLS_LDRH    = 6'd4;
  localparam logic [ClassW-1:0] CLS_LDRSB   = 6'd5;
  localparam logic [ClassW-1:0] CLS_LDRSH   = 6'd6;
  localparam logic [ClassW-1:0] CLS_STRH    = 6'd7;
  localparam logic [ClassW-1:0] CLS_MUL     = 6'd8;
  localparam logic [ClassW-1:0] CLS_MLA     = 6'd9;
  localparam logic [ClassW-1:0] CLS_UMULL   = 6'd10;
  localparam logic [ClassW-1:0] CLS_UMLAL   = 6'd11;
  localparam logic [ClassW-1:0] CLS_SMULL   = 6'd12;
  localparam logic [ClassW-1:0] CLS_SMLAL   = 6'd13;
  localparam logic [ClassW-1:0] CLS_ALU0    = 6'd14;
  localparam logic [ClassW-1:0] CLS_MRS     = 6'd30;
  localparam logic [ClassW-1:0] CLS_MSR     = 6'd31;
  localparam logic [ClassW-1:0] CLS_LDR     = 6'd32;
  localparam logic [ClassW-1:0] CLS_STR     = 6'd33;
  localparam logic [ClassW-1:0] CLS_LDM     = 6'd34;
  localparam logic [ClassW-1:0] CLS_STM     = 6'd35;

  // Halfword transfer SH field codes.
  localparam logic [1:0] SH_H  = 2'd1;
  localparam logic [1:0] SH_SB = 2'd2;
  localparam logic [1:0] SH_SH = 2'd3;

  // Data-processing opcodes that may hide a status register access, and the multiply opcodes.
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_CMN = 4'd11;
  localparam logic [3:0] OP_MUL = 4'd0;
  localparam logic [3:0] OP_MLA = 4'd1;

  // Major opcode fields.
  localparam logic [3:0] TOP_B   = 4'hA;
  localparam logic [3:0] TOP_BL  = 4'hB;
  localparam logic [1:0] GRP_DP  = 2'b00;
  localparam logic [1:0] GRP_SDT = 2'b01;
  localparam logic [2:0] GRP_BLK = 3'b100;

  // Masks and patterns of the compares.
  localparam logic [WordW-1:0] MASK_BX   = 32'h0FFF_FF00;
  localparam logic [WordW-1:0] PAT_BX    = 32'h012F_FF00;
  localparam logic [WordW-1:0] MASK_HALF = 32'h0E00_0090;
  localparam logic [WordW-1:0] PAT_HALF  = 32'h0000_0090;
  localparam logic [WordW-1:0] MASK_MUL  = 32'h0E00_00F0;
  localparam logic [WordW-1:0] PAT_MUL   = 32'h0000_0090;
  localparam logic [WordW-1:0] MASK_MULL = 32'h0F80_00F0;
  localparam logic [WordW-1:0] PAT_MULL  = 32'h0080_0090;
  localparam logic [WordW-1:0] MASK_MRS  = 32'h0FBF_0FFF;
  localparam logic [WordW-1:0] PAT_MRS   = 32'h010F_0000;
  localparam logic [WordW-1:0] MASK_MSRR = 32'h0FBF_FFF0;
  localparam logic [WordW-1:0] PAT_MSRR  = 32'h0129_F000;
  localparam logic [WordW-1:0] MASK_MSRF = 32'h0DBF_F000;
  localparam logic [WordW-1:0] PAT_MSRF  = 32'h0128_F000;

  // Result of one decode.
  typedef struct packed {
    logic [ClassW-1:0] op_class;
    logic              is_valid;
  } result_t;

endpackage

@@ rtl/cicd_decode.sv @@
// Combinational class decode of one instruction word.
// Depends on cicd_pkg for masks, class codes and the result type.
module cicd_decode import cicd_pkg::*; (
  input  logic [WordW-1:0] word_i,
  output result_t          res_o
);

  logic [ClassW-1:0] cls_branch;
  logic [ClassW-1:0] cls_half;
  logic [ClassW-1:0] cls_mul;
  logic [ClassW-1:0] cls_mull;
  logic [ClassW-1:0] cls_psr;
  logic [ClassW-1:0] cls_alu;
  logic [ClassW-1:0] cls_mem;
  logic [ClassW-1:0] cls_final;
  logic [3:0]        opcode;
  logic [1:0]        sh;

  assign opcode = word_i[24:21];
  assign sh     = word_i[6:5];

  // Branches: B and BL by bits 27:24, BX by its fixed pattern.
  always_comb begin
    cls_branch = CLS_INVALID;
    if (word_i[27:24] == TOP_B) begin
      cls_branch = CLS_B;
    end else if (word_i[27:24] == TOP_BL) begin
      cls_branch = CLS_BL;
    end else if ((word_i & MASK_BX) == PAT_BX) begin
      cls_branch = CLS_BX;
    end
  end

  // Halfword and signed transfers; a store only exists with SH = 01.
  always_comb begin
    cls_half = CLS_INVALID;
    if ((word_i & MASK_HALF) == PAT_HALF) begin
      if (word_i[20]) begin
        case (sh)
          SH_H:    cls_half = CLS_LDRH;
          SH_SB:   cls_half = CLS_LDRSB;
          SH_SH:   cls_half = CLS_LDRSH;
          default: cls_half = CLS_INVALID;
        endcase
      end else if (sh == SH_H) begin
        cls_half = CLS_STRH;
      end
    end
  end

  // Short multiplies need bits 24:21 to be MUL or MLA.
  always_comb begin
    cls_mul = CLS_INVALID;
    if ((word_i & MASK_MUL) == PAT_MUL) begin
      if (opcode == OP_MUL) begin
        cls_mul = CLS_MUL;
      end else if (opcode == OP_MLA) begin
        cls_mul = CLS_MLA;
      end
    end
  end

  // Long multiplies: bit 22 set means signed, bit 21 means accumulate.
  always_comb begin
    cls_mull = CLS_INVALID;
    if ((word_i & MASK_MULL) == PAT_MULL) begin
      case (word_i[22:21])
        2'b00:   cls_mull = CLS_UMULL;
        2'b01:   cls_mull = CLS_UMLAL;
        2'b10:   cls_mull = CLS_SMULL;
        default: cls_mull = CLS_SMLAL;
      endcase
    end
  end

  // Status register access; its class is used only for the compare opcodes.
  always_comb begin
    cls_psr = CLS_INVALID;
    if ((word_i & MASK_MRS) == PAT_MRS) begin
      cls_psr = CLS_MRS;
    end else if ((word_i & MASK_MSRR) == PAT_MSRR) begin
      cls_psr = CLS_MSR;
    end else if ((word_i & MASK_MSRF) == PAT_MSRF) begin
      cls_psr = CLS_MSR;
    end
  end

  // Data processing: for the compare opcodes a status access wins, else the opcode gives the class.
  always_comb begin
    cls_alu = CLS_INVALID;
    if (word_i[27:26] == GRP_DP) begin
      if (opcode >= OP_TST && opcode <= OP_CMN && cls_psr != CLS_INVALID) begin
        cls_alu = cls_psr;
      end else begin
        cls_alu = CLS_ALU0 + {2'b00, opcode};
      end
    end
  end

  // Single and block data transfers, load or store by bit 20.
  always_comb begin
    cls_mem = CLS_INVALID;
    if (word_i[27:26] == GRP_SDT) begin
      cls_mem = word_i[20] ? CLS_LDR : CLS_STR;
    end else if (word_i[27:25] == GRP_BLK) begin
      cls_mem = word_i[20] ? CLS_LDM : CLS_STM;
    end
  end

  // Fixed priority across the groups.
  always_comb begin
    if (cls_branch != CLS_INVALID) begin
      cls_final = cls_branch;
    end else if (cls_half != CLS_INVALID) begin
      cls_final = cls_half;
    end else if (cls_mul != CLS_INVALID) begin
      cls_final = cls_mul;
    end else if (cls_mull != CLS_INVALID) begin
      cls_final = cls_mull;
    end else if (cls_alu != CLS_INVALID) begin
      cls_final = cls_alu;
    end else begin
      cls_final = cls_mem;
    end
  end

  assign res_o.op_class = cls_final;
  assign res_o.is_valid = (cls_final != CLS_INVALID);

endmodule

@@ rtl/cpu_instruction_class_decoder_top.sv @@
// Top level of the instruction class decoder: input register, decode, result register.
// Depends on cicd_pkg, cicd_decode and assert_macros.svh.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+---------------------------
//   in      | to block  | in_valid_i / in_stall_o     | instr_word_i[31:0]
//   out     | from block| out_valid_o / out_stall_i   | op_class_o[5:0], is_valid_o
//
// A request is held in the input register after it is accepted and is decoded
// into the result register once that register is empty or drained; the result
// stays there until out_stall_i is low.
// One request is accepted every cycle while the output is not stalled.
// Reset clears both valid flags; the payload registers are not reset.
// A stall on the output holds the result and, once the input register is
// also full, raises in_stall_o in the same cycle.
`include "assert_macros.svh"

module cpu_instruction_class_decoder_top import cicd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [WordW-1:0]  instr_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ClassW-1:0] op_class_o,
  output logic              is_valid_o
);

  logic             in_valid_q;
  logic             in_valid_d;
  logic [WordW-1:0] word_q;
  logic             out_valid_q;
  logic             out_valid_d;
  result_t          res_q;
  result_t          res_dec;
  logic             out_take;
  logic             in_accept;

  // Handshake control: the result register moves when empty or drained.
  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (out_take) begin
      in_valid_d = 1'b0;
    end
  end

  assign out_valid_d = out_take ? in_valid_q : out_valid_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q <= instr_word_i;
    end
    if (out_take) begin
      res_q <= res_dec;
    end
  end

  // Class decode between the two registers.
  cicd_decode u_decode (
    .word_i (word_q),
    .res_o  (res_dec)
  );

  assign out_valid_o = out_valid_q;
  assign op_class_o  = res_q.op_class;
  assign is_valid_o  = res_q.is_valid;

  // The valid flag of a result agrees with its class code.
  `ASSERT_IMPL(a_valid_flag, out_valid_o, is_valid_o == (|op_class_o), "bad is_valid_o")
  // An accepted request always lands in the input register.
  `ASSERT_NEXT(a_in_load, in_valid_i && !in_stall_o, in_valid_q, "accepted request was lost")
  // A full input register behind a stalled output must push back.
  `ASSERT_IMPL(a_backpressure, !out_take && in_valid_q, in_stall_o, "missing input stall")

endmodule
